@@ src/twcw_pkg.sv @@
`default_nettype none

package twcw_pkg;

  localparam int TWCW_SCREEN_CELLS = 4096;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH   = 4'd0,
    CFG_WINDOW_LEFT    = 4'd1,
    CFG_WINDOW_TOP     = 4'd2,
    CFG_WINDOW_COLUMNS = 4'd3,
    CFG_WINDOW_ROWS    = 4'd4,
    CFG_TEXT_COLOUR    = 4'd5,
    CFG_CURSOR_FOLLOW  = 4'd6,
    CFG_CURSOR_HIDDEN  = 4'd7
  } cfg_reg_t;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] MAX_COLS = 8'd128;
  localparam logic [6:0] MAX_ROWS = 7'd64;

  localparam logic [7:0] RST_SCREEN_WIDTH   = 8'd80;
  localparam logic [6:0] RST_WINDOW_LEFT    = 7'd0;
  localparam logic [5:0] RST_WINDOW_TOP     = 6'd0;
  localparam logic [7:0] RST_WINDOW_COLUMNS = 8'd80;
  localparam logic [6:0] RST_WINDOW_ROWS    = 7'd50;
  localparam logic [7:0] RST_TEXT_COLOUR    = 8'd7;

  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic [11:0] read_address;
  } in_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] cursor_offset;
    logic        cursor_write;
  } out_word_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic prep;
    logic put_write;
    logic sc_read;
    logic sc_write;
    logic sc_fill;
    logic load_put;
    logic load_read;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic do_scroll;
    logic rows_one;
    logic sc_last_col;
    logic sc_moved_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ src/text_window_console_writer.sv @@
// Text console writer for one window of a character-cell screen store.
// Input channel (in_valid/in_ready/in_data): one word per item, either a
// put of one character or a read of one cell. Output channel
// (out_valid/out_ready/out_data): one result word per item, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write registers only while no item is in flight.
// A read item passes through state RDOUT, a put item through PREP and WRITE,
// before its result word is loaded; a new item is taken in the cycle after
// the result is loaded, so no item is taken before the last one is through.
// A put that moves past the bottom row scrolls the window through the
// store, one access at a time: each moved cell is read and then written,
// each cell of the bottom row is filled with a blank, then the result loads.
// After reset the store is cleared one cell per cycle, all SCREEN_CELLS
// cells, with in_ready low; config writes are taken meanwhile.
// When the receiver stalls, the result word holds in the output register and
// the next item is still accepted; it then waits for the register to free.
`default_nettype none

module text_window_console_writer import twcw_pkg::*; #(
  parameter int SCREEN_CELLS = TWCW_SCREEN_CELLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  twcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  twcw_dp #(
    .SCREEN_CELLS (SCREEN_CELLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ src/twcw_ctrl.sv @@
`default_nettype none

module twcw_ctrl import twcw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_func,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         in_ready
);

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_PREP    = 9'b000000100,
    ST_WRITE   = 9'b000001000,
    ST_SC_RD   = 9'b000010000,
    ST_SC_WR   = 9'b000100000,
    ST_SC_FILL = 9'b001000000,
    ST_FIN     = 9'b010000000,
    ST_RDOUT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = in_func ? ST_RDOUT : ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.put_write = 1'b1;
        if (sts.do_scroll) begin
          state_next = sts.rows_one ? ST_SC_FILL : ST_SC_RD;
        end else if (sts.out_free) begin
          cmd.load_put = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_SC_RD: begin
        cmd.sc_read = 1'b1;
        state_next  = ST_SC_WR;
      end
      ST_SC_WR: begin
        cmd.sc_write = 1'b1;
        if (sts.sc_last_col && sts.sc_moved_done) begin
          state_next = ST_SC_FILL;
        end else begin
          state_next = ST_SC_RD;
        end
      end
      ST_SC_FILL: begin
        cmd.sc_fill = 1'b1;
        if (sts.sc_last_col) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_put = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_RDOUT: begin
        if (sts.out_free) begin
          cmd.load_read = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_put || cmd.load_read) |-> sts.out_free)
    else $error("result loaded while output word still held");

  a_scroll_pairs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SC_WR) |-> ($past(state) == ST_SC_RD))
    else $error("scroll write without a preceding read");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.accept, cmd.prep, cmd.put_write,
              cmd.sc_read, cmd.sc_write, cmd.sc_fill}))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

@@ src/twcw_dp.sv @@
`default_nettype none

module twcw_dp import twcw_pkg::*; #(
  parameter int SCREEN_CELLS = TWCW_SCREEN_CELLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire in_word_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output out_word_t                  out_data
);

  localparam int          ADDR_W = $clog2(SCREEN_CELLS);
  localparam logic [16:0] CELLS  = 17'(SCREEN_CELLS);

  logic [7:0] screen_width;
  logic [6:0] window_left;
  logic [5:0] window_top;
  logic [7:0] window_columns;
  logic [6:0] window_rows;
  logic [7:0] text_colour;
  logic       cursor_follow;
  logic       cursor_hidden;

  logic [6:0] cursor_col;
  logic [5:0] cursor_row;

  logic [7:0]  ch_q;
  logic        wr_en;
  logic [6:0]  wr_col;
  logic [15:0] wr_data;
  logic        do_scroll;
  logic [6:0]  col_f;
  logic [14:0] prod_wr;
  logic [14:0] prod_cur;
  logic [14:0] prod_base;

  logic [15:0] dst_base;
  logic [15:0] src_base;
  logic [6:0]  sc_col;
  logic [5:0]  sc_row;

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_last;

  logic [15:0] mem [SCREEN_CELLS];
  logic [15:0] mem_rdata;
  logic        rd_ok;
  logic        mem_we;
  logic [15:0] mem_waddr;
  logic [15:0] mem_wdata;
  logic        mem_re;
  logic [15:0] mem_raddr;

  logic [7:0]  eff_cols;
  logic [6:0]  eff_rows;
  logic [6:0]  col_s;
  logic [5:0]  row_s;
  logic [7:0]  col_n;
  logic [6:0]  row_n;
  logic [6:0]  row_f;
  logic        scroll_n;
  logic        wr_en_n;
  logic [5:0]  wr_row_n;
  logic [6:0]  wr_col_n;
  logic [7:0]  wr_char_n;
  logic [6:0]  top_wr;
  logic [6:0]  top_cur;

  logic [15:0] put_addr;
  logic [15:0] cur_off;
  logic [15:0] src_addr;
  logic [15:0] dst_addr;
  logic [15:0] blank;
  logic        sc_last_col;
  logic        sc_step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= RST_SCREEN_WIDTH;
      window_left    <= RST_WINDOW_LEFT;
      window_top     <= RST_WINDOW_TOP;
      window_columns <= RST_WINDOW_COLUMNS;
      window_rows    <= RST_WINDOW_ROWS;
      text_colour    <= RST_TEXT_COLOUR;
      cursor_follow  <= 1'b0;
      cursor_hidden  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:   screen_width   <= cfg_data;
        CFG_WINDOW_LEFT:    window_left    <= cfg_data[6:0];
        CFG_WINDOW_TOP:     window_top     <= cfg_data[5:0];
        CFG_WINDOW_COLUMNS: window_columns <= cfg_data;
        CFG_WINDOW_ROWS:    window_rows    <= cfg_data[6:0];
        CFG_TEXT_COLOUR:    text_colour    <= cfg_data;
        CFG_CURSOR_FOLLOW:  cursor_follow  <= cfg_data[0];
        CFG_CURSOR_HIDDEN:  cursor_hidden  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign eff_cols = (window_columns == 8'd0) ? 8'd1 :
                    (window_columns > MAX_COLS) ? MAX_COLS : window_columns;
  assign eff_rows = (window_rows == 7'd0) ? 7'd1 :
                    (window_rows > MAX_ROWS) ? MAX_ROWS : window_rows;

  assign col_s = ({1'b0, cursor_col} >= eff_cols) ? 7'(eff_cols - 8'd1) : cursor_col;
  assign row_s = ({1'b0, cursor_row} >= eff_rows) ? 6'(eff_rows - 7'd1) : cursor_row;

  // character decode
  always_comb begin
    col_n     = {1'b0, col_s};
    row_n     = {1'b0, row_s};
    wr_en_n   = 1'b0;
    wr_row_n  = row_s;
    wr_col_n  = col_s;
    wr_char_n = ch_q;
    unique case (ch_q)
      CH_CR: begin
        col_n = 8'd0;
      end
      CH_LF: begin
        col_n = 8'd0;
        row_n = {1'b0, row_s} + 7'd1;
      end
      CH_BS: begin
        wr_en_n   = 1'b1;
        wr_char_n = CH_SPACE;
        if (col_s != 7'd0) begin
          col_n = {1'b0, col_s} - 8'd1;
        end else if (row_s != 6'd0) begin
          row_n = {1'b0, row_s} - 7'd1;
          col_n = eff_cols - 8'd1;
        end
        wr_row_n = row_n[5:0];
        wr_col_n = col_n[6:0];
      end
      default: begin
        if (!ch_q[7] && (ch_q >= CH_SPACE)) begin
          wr_en_n = 1'b1;
          col_n   = {1'b0, col_s} + 8'd1;
          if (col_n == eff_cols) begin
            col_n = 8'd0;
            row_n = {1'b0, row_s} + 7'd1;
          end
        end
      end
    endcase
  end

  assign scroll_n = (row_n == eff_rows);
  assign row_f    = scroll_n ? (row_n - 7'd1) : row_n;
  assign top_wr   = {1'b0, window_top} + {1'b0, wr_row_n};
  assign top_cur  = {1'b0, window_top} + {1'b0, row_f[5:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 7'd0;
      cursor_row <= 6'd0;
    end else if (cmd.prep) begin
      cursor_col <= col_n[6:0];
      cursor_row <= row_f[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_q <= in_data.char_code;
    end
    if (cmd.prep) begin
      wr_en     <= wr_en_n;
      wr_col    <= wr_col_n;
      wr_data   <= {text_colour, wr_char_n};
      do_scroll <= scroll_n;
      col_f     <= col_n[6:0];
      prod_wr   <= {8'd0, top_wr} * {7'd0, screen_width};
      prod_cur  <= {8'd0, top_cur} * {7'd0, screen_width};
      prod_base <= {9'd0, window_top} * {7'd0, screen_width};
    end
  end

  assign put_addr = 16'(prod_wr) + {9'd0, window_left} + {9'd0, wr_col};
  assign cur_off  = 16'(prod_cur) + {9'd0, window_left} + {9'd0, col_f};
  assign src_addr = src_base + {9'd0, window_left} + {9'd0, sc_col};
  assign dst_addr = dst_base + {9'd0, window_left} + {9'd0, sc_col};
  assign blank    = {text_colour, CH_SPACE};

  // scroll walk over the window
  assign sc_last_col = ({1'b0, sc_col} == (eff_cols - 8'd1));
  assign sc_step     = cmd.sc_write || cmd.sc_fill;

  always_ff @(posedge clk) begin
    if (cmd.put_write && do_scroll) begin
      dst_base <= 16'(prod_base);
      src_base <= 16'(prod_base) + {8'd0, screen_width};
      sc_col   <= 7'd0;
      sc_row   <= 6'd0;
    end else if (sc_step) begin
      if (sc_last_col) begin
        sc_col   <= 7'd0;
        sc_row   <= sc_row + 6'd1;
        dst_base <= src_base;
        src_base <= src_base + {8'd0, screen_width};
      end else begin
        sc_col <= sc_col + 7'd1;
      end
    end
  end

  // clearing pass after reset
  assign clr_last = (clr_addr == ADDR_W'(SCREEN_CELLS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step && !clr_last) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // store ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = 16'd0;
    mem_wdata = 16'd0;
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = 16'(clr_addr);
    end else if (cmd.put_write) begin
      mem_we    = wr_en && ({1'b0, put_addr} < CELLS);
      mem_waddr = put_addr;
      mem_wdata = wr_data;
    end else if (cmd.sc_write) begin
      mem_we    = ({1'b0, dst_addr} < CELLS);
      mem_waddr = dst_addr;
      mem_wdata = rd_ok ? mem_rdata : 16'd0;
    end else if (cmd.sc_fill) begin
      mem_we    = ({1'b0, dst_addr} < CELLS);
      mem_waddr = dst_addr;
      mem_wdata = blank;
    end
  end

  assign mem_re    = (cmd.accept && in_data.func) || cmd.sc_read;
  assign mem_raddr = cmd.sc_read ? src_addr : {4'd0, in_data.read_address};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr[ADDR_W-1:0]];
      rd_ok     <= ({1'b0, mem_raddr} < CELLS);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_put || cmd.load_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_put) begin
      out_data.read_data <= 16'd0;
      if (cursor_follow && !cursor_hidden) begin
        out_data.cursor_offset <= cur_off;
        out_data.cursor_write  <= 1'b1;
      end else begin
        out_data.cursor_offset <= 16'd0;
        out_data.cursor_write  <= 1'b0;
      end
    end else if (cmd.load_read) begin
      out_data.read_data     <= rd_ok ? mem_rdata : 16'd0;
      out_data.cursor_offset <= 16'd0;
      out_data.cursor_write  <= 1'b0;
    end
  end

  assign sts.clr_last      = clr_last;
  assign sts.do_scroll     = do_scroll;
  assign sts.rows_one      = (eff_rows == 7'd1);
  assign sts.sc_last_col   = sc_last_col;
  assign sts.sc_moved_done = (({1'b0, sc_row} + 7'd2) == eff_rows);
  assign sts.out_free      = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ tb/console_tb_pkg.sv @@
package console_tb_pkg;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // first code of the upper half, never printable
  localparam logic [7:0] FIRST_HIGH_CODE = 8'h80;

  typedef struct packed {
    logic [7:0] screen_width;
    logic [7:0] window_left;
    logic [7:0] window_top;
    logic [7:0] window_columns;
    logic [7:0] window_rows;
    logic [7:0] text_colour;
    logic [7:0] cursor_follow;
    logic [7:0] cursor_hidden;
  } console_setup_t;

endpackage

@@ tb/console_checker.sv @@
module console_checker
  import twcw_pkg::*;
  import console_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  logic [7:0] scr_w;
  logic [6:0] win_left;
  logic [5:0] win_top;
  logic [7:0] win_cols;
  logic [6:0] win_rows;
  logic [7:0] colour;
  logic       follow;
  logic       hidden;

  int unsigned cur_col;
  int unsigned cur_row;
  logic [15:0] mirror [TWCW_SCREEN_CELLS];
  out_word_t   expected_words [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
    return (win_top + r) * scr_w + win_left + c;
  endfunction

  function automatic void poke(int unsigned a, logic [15:0] v);
    if (a < TWCW_SCREEN_CELLS) mirror[a] = v;
  endfunction

  function automatic logic [15:0] peek(int unsigned a);
    return (a < TWCW_SCREEN_CELLS) ? mirror[a] : 16'h0000;
  endfunction

  function automatic void scroll_window(int unsigned cols, int unsigned rows);
    int unsigned k;
    int unsigned src;
    for (k = 0; k < cols * (rows - 1); k++) begin
      src = k + cols;
      poke(cell_addr(k / cols, k % cols), peek(cell_addr(src / cols, src % cols)));
    end
    for (; k < cols * rows; k++) poke(cell_addr(k / cols, k % cols), {colour, CH_SPACE});
  endfunction

  function automatic out_word_t console_response(in_word_t w);
    out_word_t   r;
    int unsigned cols;
    int unsigned rows;
    int unsigned col;
    int unsigned row;
    int unsigned lin;
    r = '0;
    if (w.func == FUNC_READ) begin
      r.read_data = peek(w.read_address);
      return r;
    end
    cols = (win_cols == 0) ? 1 : (win_cols > MAX_COLS) ? MAX_COLS : win_cols;
    rows = (win_rows == 0) ? 1 : (win_rows > MAX_ROWS) ? MAX_ROWS : win_rows;
    col  = (cur_col < cols) ? cur_col : cols - 1;
    row  = (cur_row < rows) ? cur_row : rows - 1;
    case (w.char_code)
      CH_CR: col = 0;
      CH_LF: begin
        col = 0;
        row++;
      end
      CH_BS: begin
        lin = col + row * cols;
        if (lin > 0) lin--;
        if (col > 0) begin
          col--;
        end else if (row > 0) begin
          row--;
          col = cols - 1;
        end
        poke(cell_addr(lin / cols, lin % cols), {colour, CH_SPACE});
      end
      default: begin
        if (w.char_code >= CH_SPACE && w.char_code < FIRST_HIGH_CODE) begin
          poke(cell_addr(row, col), {colour, w.char_code});
          col++;
          if (col == cols) begin
            col = 0;
            row++;
          end
        end
      end
    endcase
    if (row == rows) begin
      scroll_window(cols, rows);
      row--;
    end
    cur_col = col;
    cur_row = row;
    if (follow && !hidden) begin
      r.cursor_offset = 16'((col + win_left) + (row + win_top) * scr_w);
      r.cursor_write  = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      scr_w    = RST_SCREEN_WIDTH;
      win_left = RST_WINDOW_LEFT;
      win_top  = RST_WINDOW_TOP;
      win_cols = RST_WINDOW_COLUMNS;
      win_rows = RST_WINDOW_ROWS;
      colour   = RST_TEXT_COLOUR;
      follow   = 1'b0;
      hidden   = 1'b0;
      cur_col  = 0;
      cur_row  = 0;
      foreach (mirror[i]) mirror[i] = '0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t result word expected none got %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("cursor_offset", want.cursor_offset, out_data.cursor_offset);
          check_field("cursor_write", 16'(want.cursor_write), 16'(out_data.cursor_write));
        end
      end
      if (in_valid && in_ready) expected_words.push_back(console_response(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:   scr_w    = cfg_data;
          CFG_WINDOW_LEFT:    win_left = cfg_data[6:0];
          CFG_WINDOW_TOP:     win_top  = cfg_data[5:0];
          CFG_WINDOW_COLUMNS: win_cols = cfg_data;
          CFG_WINDOW_ROWS:    win_rows = cfg_data[6:0];
          CFG_TEXT_COLOUR:    colour   = cfg_data;
          CFG_CURSOR_FOLLOW:  follow   = cfg_data[0];
          CFG_CURSOR_HIDDEN:  hidden   = cfg_data[0];
          default: ;
        endcase
      end
    end
    outstanding = expected_words.size();
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  import twcw_pkg::*;
  import console_tb_pkg::*;

  logic clk = 1'b0;
  logic rst;

  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  bit gaps_on;
  int sent;

  always #5 clk = ~clk;

  text_window_console_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  console_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= 13) : 1'b1;
  end

  function automatic in_word_t put_word(logic [7:0] ch);
    return '{func: FUNC_PUT, char_code: ch, read_address: 12'($urandom)};
  endfunction

  function automatic in_word_t read_word(logic [11:0] a);
    return '{func: FUNC_READ, char_code: 8'($urandom), read_address: a};
  endfunction

  function automatic in_word_t random_word(console_setup_t s);
    int unsigned cols;
    int unsigned rows;
    int unsigned a;
    int unsigned pick;
    cols = (s.window_columns == 0) ? 1 :
           (s.window_columns > MAX_COLS) ? MAX_COLS : s.window_columns;
    rows = (s.window_rows[6:0] == 0) ? 1 :
           (s.window_rows[6:0] > MAX_ROWS) ? MAX_ROWS : s.window_rows[6:0];
    pick = $urandom_range(0, 99);
    if (pick < 40) return put_word(8'($urandom_range(32, 127)));
    if (pick < 50) return put_word(CH_LF);
    if (pick < 55) return put_word(CH_CR);
    if (pick < 63) return put_word(CH_BS);
    if (pick < 73) return put_word(8'($urandom));
    if (pick < 87) return read_word(12'($urandom));
    a = (s.window_top[5:0] + $urandom_range(0, rows - 1)) * s.screen_width
        + s.window_left[6:0] + $urandom_range(0, cols - 1);
    if (a >= TWCW_SCREEN_CELLS) a = $urandom_range(0, TWCW_SCREEN_CELLS - 1);
    return read_word(12'(a));
  endfunction

  function automatic console_setup_t random_setup();
    console_setup_t s;
    int unsigned    pick;
    s.screen_width = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(129, 255))
                                                 : 8'($urandom_range(1, 128));
    s.window_left = 8'($urandom);
    s.window_top  = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      s.window_columns = 8'd0;
      s.window_rows    = {1'($urandom), 7'($urandom_range(1, 6))};
    end else if (pick == 1) begin
      s.window_columns = 8'($urandom_range(129, 255));
      s.window_rows    = {1'($urandom), 7'($urandom_range(0, 2))};
    end else if (pick == 2) begin
      s.window_columns = 8'($urandom_range(1, 2));
      s.window_rows    = {1'($urandom), 7'($urandom_range(65, 127))};
    end else begin
      s.window_columns = 8'($urandom_range(1, 12));
      s.window_rows    = {1'($urandom), 7'($urandom_range(0, 6))};
    end
    s.text_colour   = 8'($urandom);
    s.cursor_follow = {7'($urandom), 1'($urandom_range(0, 3) != 0)};
    s.cursor_hidden = {7'($urandom), 1'($urandom_range(0, 3) == 0)};
    return s;
  endfunction

  task automatic send_word(in_word_t w);
    if (gaps_on && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // hold the input and wait for every result word
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setup(console_setup_t s);
    drain();
    write_reg(CFG_SCREEN_WIDTH, s.screen_width);
    write_reg(CFG_WINDOW_LEFT, s.window_left);
    write_reg(CFG_WINDOW_TOP, s.window_top);
    write_reg(CFG_WINDOW_COLUMNS, s.window_columns);
    write_reg(CFG_WINDOW_ROWS, s.window_rows);
    write_reg(CFG_TEXT_COLOUR, s.text_colour);
    write_reg(CFG_CURSOR_FOLLOW, s.cursor_follow);
    write_reg(CFG_CURSOR_HIDDEN, s.cursor_hidden);
    // unused index, must be ignored
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(CFG_CURSOR_HIDDEN) + CFG_IDX_W'($urandom_range(1, 8)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(console_setup_t s, int n);
    apply_setup(s);
    repeat (n) send_word(random_word(s));
  endtask

  initial begin
    console_setup_t s;
    int             phase;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    sent      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // small window: edges of the code space, wrap, backspace, scroll, reads
    s = '{8'd20, 8'd3, 8'd2, 8'd5, 8'd3, 8'hA5, 8'd1, 8'd0};
    apply_setup(s);
    send_word(put_word(CH_BS));
    send_word(put_word("A"));
    send_word(put_word(CH_SPACE));
    send_word(put_word(8'h7F));
    send_word(put_word(8'h1F));
    send_word(put_word(FIRST_HIGH_CODE));
    send_word(put_word(8'hFF));
    send_word(put_word(8'h00));
    send_word(put_word(CH_CR));
    send_word(put_word(CH_BS));
    send_word(put_word("H"));
    send_word(put_word("e"));
    send_word(put_word("l"));
    send_word(put_word("l"));
    send_word(put_word("o"));
    send_word(put_word(CH_BS));
    send_word(put_word(CH_LF));
    send_word(put_word(CH_LF));
    send_word(put_word(CH_LF));
    send_word(read_word(12'd43));
    send_word(read_word(12'd0));
    send_word(read_word(12'hFFF));
    send_word(put_word("Z"));

    // park the cursor on row 0, then fill the largest window until it scrolls
    s = '{8'd128, 8'd0, 8'd0, 8'd128, 8'd1, 8'h1E, 8'd1, 8'd0};
    apply_setup(s);
    send_word(put_word(CH_CR));
    s.window_rows = 8'd64;
    apply_setup(s);
    repeat (63) send_word(put_word(CH_LF));
    repeat (8) send_word(put_word(8'($urandom_range(32, 127))));
    repeat (4) send_word(random_word(s));
    send_word(put_word(CH_LF));
    repeat (3) send_word(put_word(8'($urandom_range(32, 127))));
    send_word(put_word(CH_LF));
    send_word(read_word(12'($urandom_range(0, 127))));

    run_phase('{8'd1, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'h00, 8'h01, 8'hFF}, 60);
    run_phase('{8'd255, 8'd0, 8'd63, 8'd255, 8'd1, 8'hFF, 8'h01, 8'hFE}, 60);
    run_phase('{8'd128, 8'd0, 8'd31, 8'd128, 8'd2, 8'h5A, 8'h01, 8'h00}, 60);
    run_phase('{8'd80, 8'd0, 8'd0, 8'd2, 8'd127, 8'h3C, 8'h00, 8'h00}, 60);

    phase = 0;
    while (sent < 1600) begin
      gaps_on = !(phase >= 3 && phase <= 5);
      run_phase(random_setup(), $urandom_range(40, 110));
      phase++;
    end
    gaps_on = 1'b1;

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

@@ text_window_console_writer.f @@
src/twcw_pkg.sv
src/twcw_ctrl.sv
src/twcw_dp.sv
src/text_window_console_writer.sv
tb/console_tb_pkg.sv
tb/console_checker.sv
tb/testbench.sv
